>>> design/gfa_pkg.sv
`timescale 1ns / 1ps

package gfa_pkg;

  // Field sizes
  localparam int MAX_DEGREE   = 4;
  localparam int COEF_BITS    = 11;
  localparam int EXP_BITS     = 32;
  localparam int DEG_BITS     = 4;
  localparam int LANE_BITS    = $clog2(MAX_DEGREE);
  localparam int CNT_BITS     = LANE_BITS + 1;
  localparam int NUM_REGS     = 2 + MAX_DEGREE;
  localparam int CFG_IDX_BITS = $clog2(NUM_REGS);
  localparam int C_ENTRIES    = 2 * MAX_DEGREE - 1;
  localparam int C_IDX_BITS   = $clog2(C_ENTRIES);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_DEGREE  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_POLY0   = CFG_IDX_BITS'(2);

  // Operation codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_POW = 2'd3;

  typedef logic [COEF_BITS-1:0] coef_t;
  typedef coef_t [MAX_DEGREE-1:0] vec_t;

  // Shared multiply-accumulate unit request and response
  typedef struct packed {
    logic  start;
    logic  sub;
    coef_t x;
    coef_t y;
    coef_t acc;
  } mac_req_t;

  typedef struct packed {
    logic  done;
    coef_t res;
  } mac_rsp_t;

endpackage

>>> design/gfa_req_if.sv
`timescale 1ns / 1ps

interface gfa_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [gfa_pkg::COEF_BITS-1:0]  a_coef0;
  logic [gfa_pkg::COEF_BITS-1:0]  a_coef1;
  logic [gfa_pkg::COEF_BITS-1:0]  a_coef2;
  logic [gfa_pkg::COEF_BITS-1:0]  a_coef3;
  logic [gfa_pkg::COEF_BITS-1:0]  b_coef0;
  logic [gfa_pkg::COEF_BITS-1:0]  b_coef1;
  logic [gfa_pkg::COEF_BITS-1:0]  b_coef2;
  logic [gfa_pkg::COEF_BITS-1:0]  b_coef3;
  logic [gfa_pkg::EXP_BITS-1:0]   exponent;

  modport source (output valid, func, a_coef0, a_coef1, a_coef2, a_coef3,
                  b_coef0, b_coef1, b_coef2, b_coef3, exponent, input ready);
  modport sink (input valid, func, a_coef0, a_coef1, a_coef2, a_coef3,
                b_coef0, b_coef1, b_coef2, b_coef3, exponent, output ready);
endinterface

>>> design/gfa_rsp_if.sv
`timescale 1ns / 1ps

interface gfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [gfa_pkg::COEF_BITS-1:0]  r_coef0;
  logic [gfa_pkg::COEF_BITS-1:0]  r_coef1;
  logic [gfa_pkg::COEF_BITS-1:0]  r_coef2;
  logic [gfa_pkg::COEF_BITS-1:0]  r_coef3;

  modport source (output valid, r_coef0, r_coef1, r_coef2, r_coef3, input ready);
  modport sink (input valid, r_coef0, r_coef1, r_coef2, r_coef3, output ready);
endinterface

>>> design/gfa_mac.sv
`timescale 1ns / 1ps

// Bit-serial modular multiply-accumulate: res = (acc +/- x*y) mod q.
// x is walked MSB first, one bit a cycle; y and acc must be below q.
module gfa_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  gfa_pkg::coef_t       q,
  input  gfa_pkg::mac_req_t    req,
  output gfa_pkg::mac_rsp_t    rsp
);

  localparam int W     = gfa_pkg::COEF_BITS + 1;
  localparam int CNT_W = $clog2(gfa_pkg::COEF_BITS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(gfa_pkg::COEF_BITS);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  gfa_pkg::coef_t       xs;
  gfa_pkg::coef_t       y;
  gfa_pkg::coef_t       acc;
  logic                 sub;
  gfa_pkg::coef_t       prod;
  gfa_pkg::coef_t       prod_next;
  gfa_pkg::coef_t       fin;
  logic [W-1:0]         qw;
  logic [W-1:0]         dbl;
  logic [W-1:0]         d1;
  logic [W-1:0]         s;
  logic [W-1:0]         s2;
  logic [W-1:0]         addend;
  logic [W-1:0]         f;

  // Double, conditionally add y, reduce each time by one subtract
  always_comb begin
    qw        = {1'b0, q};
    dbl       = {prod, 1'b0};
    d1        = (dbl >= qw) ? dbl - qw : dbl;
    s         = d1 + {1'b0, y};
    s2        = (s >= qw) ? s - qw : s;
    prod_next = xs[gfa_pkg::COEF_BITS-1] ? s2[gfa_pkg::COEF_BITS-1:0]
                                         : d1[gfa_pkg::COEF_BITS-1:0];
    addend    = sub ? qw - {1'b0, prod} : {1'b0, prod};
    f         = {1'b0, acc} + addend;
    fin       = (f >= qw) ? gfa_pkg::COEF_BITS'(f - qw) : f[gfa_pkg::COEF_BITS-1:0];
  end

  // Sequence the bit steps and the final accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          cnt  <= '0;
          xs   <= req.x;
          y    <= req.y;
          acc  <= req.acc;
          sub  <= req.sub;
          prod <= '0;
        end
      end else if (cnt != LAST) begin
        prod <= prod_next;
        xs   <= {xs[gfa_pkg::COEF_BITS-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end else begin
        rsp.res  <= fin;
        rsp.done <= 1'b1;
        busy     <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_res_below_q: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (rsp.res < q))
    else $error("mac result not reduced");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy)
    else $error("mac done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt != LAST) |=> busy)
    else $error("mac dropped busy early");
`endif

endmodule

>>> design/extension_field_alu.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                   | Handshake
// req     | in  | func, a_coef0..3, b_coef0..3, exponent    | valid/ready
// rsp     | out | r_coef0..3                                | valid/ready
// cfg     | in  | cfg_index, cfg_data                       | cfg_we, no stall
//
// One item at a time; req.ready is high only while idle. Every coefficient
// step runs on one bit-serial multiply-accumulate unit.
// Operand reduction takes 3n steps; a field multiply n*n + n*(n-1) steps;
// a power one or two multiplies per exponent bit up to its top set bit.
// Add and subtract take 3n steps plus the lane-wise add state. Reset is synchronous.
// A finished result waits in the output register until rsp.ready.
module extension_field_alu (
  input  logic                                   clk,
  input  logic                                   rst,
  gfa_req_if.sink                                req,
  gfa_rsp_if.source                              rsp,
  input  logic                                   cfg_we,
  input  logic [gfa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [gfa_pkg::COEF_BITS-1:0]          cfg_data
);

  localparam int LB = gfa_pkg::LANE_BITS;
  localparam int CB = gfa_pkg::C_IDX_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RED   = 8'b00000010,
    S_ADD   = 8'b00000100,
    S_MPROD = 8'b00001000,
    S_MRED  = 8'b00010000,
    S_COPY  = 8'b00100000,
    S_PSTEP = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  // Operand selects for the field multiply
  localparam logic [1:0] SEL_A    = 2'd0;
  localparam logic [1:0] SEL_B    = 2'd1;
  localparam logic [1:0] SEL_R    = 2'd2;
  localparam logic [1:0] SEL_BASE = 2'd3;

  state_t                          state;
  gfa_pkg::coef_t                  modulus;
  logic [gfa_pkg::DEG_BITS-1:0]    degree;
  gfa_pkg::vec_t                   poly;

  logic [1:0]                      func;
  logic [gfa_pkg::EXP_BITS-1:0]    e;
  logic [gfa_pkg::CNT_BITS-1:0]    n;
  gfa_pkg::vec_t                   a;
  gfa_pkg::vec_t                   b;
  gfa_pkg::vec_t                   p;
  gfa_pkg::vec_t                   rr;
  gfa_pkg::vec_t                   base;
  gfa_pkg::coef_t [gfa_pkg::C_ENTRIES-1:0] c;
  logic [LB-1:0]                   i;
  logic [LB-1:0]                   j;
  logic [CB-1:0]                   k;
  logic [1:0]                      rsel;
  logic [1:0]                      xsel;
  logic [1:0]                      ysel;
  logic                            dest_base;
  logic                            issued;

  gfa_pkg::mac_req_t               mac_req;
  gfa_pkg::mac_rsp_t               mac_rsp;
  gfa_pkg::vec_t                   xv;
  gfa_pkg::vec_t                   yv;
  gfa_pkg::vec_t                   in_a;
  gfa_pkg::vec_t                   in_b;
  gfa_pkg::vec_t                   addsub;
  logic [LB-1:0]                   last_lane;
  logic [CB-1:0]                   ij;
  logic [CB-1:0]                   d;
  logic [gfa_pkg::CNT_BITS-1:0]    n_eff;
  logic [gfa_pkg::COEF_BITS:0]     sum_w;

  function automatic gfa_pkg::vec_t pick(input logic [1:0] sel, input gfa_pkg::vec_t va,
                                         input gfa_pkg::vec_t vb, input gfa_pkg::vec_t vr,
                                         input gfa_pkg::vec_t vbase);
    gfa_pkg::vec_t v;
    case (sel)
      SEL_A:    v = va;
      SEL_B:    v = vb;
      SEL_R:    v = vr;
      SEL_BASE: v = vbase;
      default:  v = va;
    endcase
    return v;
  endfunction

  // Decode degree, gather input lanes
  always_comb begin
    if (degree == '0) begin
      n_eff = gfa_pkg::CNT_BITS'(1);
    end else if (degree > gfa_pkg::DEG_BITS'(gfa_pkg::MAX_DEGREE)) begin
      n_eff = gfa_pkg::CNT_BITS'(gfa_pkg::MAX_DEGREE);
    end else begin
      n_eff = gfa_pkg::CNT_BITS'(degree);
    end
    in_a = {req.a_coef3, req.a_coef2, req.a_coef1, req.a_coef0};
    in_b = {req.b_coef3, req.b_coef2, req.b_coef1, req.b_coef0};
    for (int l = 0; l < gfa_pkg::MAX_DEGREE; l++) begin
      if (gfa_pkg::CNT_BITS'(l) >= n_eff) begin
        in_a[l] = '0;
        in_b[l] = '0;
      end
    end
  end

  // Lane-wise add or subtract mod q
  always_comb begin
    sum_w = '0;
    for (int l = 0; l < gfa_pkg::MAX_DEGREE; l++) begin
      if (func == gfa_pkg::FUNC_SUB) begin
        sum_w = {1'b0, a[l]} + {1'b0, modulus} - {1'b0, b[l]};
      end else begin
        sum_w = {1'b0, a[l]} + {1'b0, b[l]};
      end
      if (sum_w >= {1'b0, modulus}) begin
        sum_w = sum_w - {1'b0, modulus};
      end
      addsub[l] = sum_w[gfa_pkg::COEF_BITS-1:0];
    end
  end

  // Build the request for the shared unit
  always_comb begin
    last_lane = LB'(n - 1'b1);
    ij        = CB'(i) + CB'(j);
    d         = CB'(k - CB'(n) + CB'(j));
    xv        = pick(xsel, a, b, rr, base);
    yv        = pick(ysel, a, b, rr, base);
    mac_req   = '0;
    case (state)
      S_RED: begin
        mac_req.start = !issued;
        mac_req.y     = gfa_pkg::COEF_BITS'(1);
        case (rsel)
          2'd0:    mac_req.x = a[i];
          2'd1:    mac_req.x = b[i];
          default: mac_req.x = p[i];
        endcase
      end
      S_MPROD: begin
        mac_req.start = !issued;
        mac_req.x     = xv[i];
        mac_req.y     = yv[j];
        mac_req.acc   = c[ij];
      end
      S_MRED: begin
        mac_req.start = !issued;
        mac_req.sub   = 1'b1;
        mac_req.x     = c[k];
        mac_req.y     = p[j];
        mac_req.acc   = c[d];
      end
      default: mac_req = '0;
    endcase
  end

  gfa_mac u_mac (
    .clk (clk),
    .rst (rst),
    .q   (modulus),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= gfa_pkg::COEF_BITS'(2);
      degree  <= gfa_pkg::DEG_BITS'(1);
      poly    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gfa_pkg::REG_MODULUS) begin
        modulus <= cfg_data;
      end else if (cfg_index == gfa_pkg::REG_DEGREE) begin
        degree <= cfg_data[gfa_pkg::DEG_BITS-1:0];
      end else if (cfg_index >= gfa_pkg::REG_POLY0 &&
                   cfg_index < gfa_pkg::CFG_IDX_BITS'(gfa_pkg::NUM_REGS)) begin
        poly[LB'(cfg_index - gfa_pkg::REG_POLY0)] <= cfg_data;
      end
    end
  end

  assign req.ready = (state == S_IDLE);

  // Sequence one transaction through the shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      if (mac_req.start) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func <= req.func;
            e    <= req.exponent;
            n    <= n_eff;
            a    <= in_a;
            b    <= in_b;
            rr   <= '0;
            base <= '0;
            i    <= '0;
            j    <= '0;
            rsel <= 2'd0;
            for (int l = 0; l < gfa_pkg::MAX_DEGREE; l++) begin
              p[l] <= (gfa_pkg::CNT_BITS'(l) < n_eff) ? poly[l] : '0;
            end
            state <= (modulus < gfa_pkg::COEF_BITS'(2)) ? S_DONE : S_RED;
          end
        end
        S_RED: begin
          if (mac_rsp.done) begin
            issued <= 1'b0;
            case (rsel)
              2'd0:    a[i] <= mac_rsp.res;
              2'd1:    b[i] <= mac_rsp.res;
              default: p[i] <= mac_rsp.res;
            endcase
            if (i == last_lane) begin
              i <= '0;
              if (rsel == 2'd2) begin
                if (func == gfa_pkg::FUNC_ADD || func == gfa_pkg::FUNC_SUB) begin
                  state <= S_ADD;
                end else if (func == gfa_pkg::FUNC_MUL) begin
                  xsel      <= SEL_A;
                  ysel      <= SEL_B;
                  dest_base <= 1'b0;
                  c         <= '0;
                  state     <= S_MPROD;
                end else begin
                  // start the power from the reduced first operand
                  rr[0] <= gfa_pkg::COEF_BITS'(1);
                  base  <= a;
                  state <= S_PSTEP;
                end
              end else begin
                rsel <= rsel + 2'd1;
              end
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        S_ADD: begin
          rr    <= addsub;
          state <= S_DONE;
        end
        S_MPROD: begin
          if (mac_rsp.done) begin
            issued <= 1'b0;
            c[ij]  <= mac_rsp.res;
            if (j == last_lane) begin
              j <= '0;
              if (i == last_lane) begin
                i <= '0;
                if (n == gfa_pkg::CNT_BITS'(1)) begin
                  state <= S_COPY;
                end else begin
                  k     <= CB'({n, 1'b0} - 2'd2);
                  state <= S_MRED;
                end
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_MRED: begin
          if (mac_rsp.done) begin
            issued <= 1'b0;
            c[d]   <= mac_rsp.res;
            if (j == last_lane) begin
              j <= '0;
              if (k == CB'(n)) begin
                state <= S_COPY;
              end else begin
                k <= k - 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_COPY: begin
          for (int l = 0; l < gfa_pkg::MAX_DEGREE; l++) begin
            if (gfa_pkg::CNT_BITS'(l) < n) begin
              if (dest_base) begin
                base[l] <= c[l];
              end else begin
                rr[l] <= c[l];
              end
            end
          end
          state <= (func == gfa_pkg::FUNC_MUL) ? S_DONE : S_PSTEP;
        end
        S_PSTEP: begin
          c <= '0;
          if (e == '0) begin
            state <= S_DONE;
          end else if (e[0]) begin
            e[0]      <= 1'b0;
            xsel      <= SEL_R;
            ysel      <= SEL_BASE;
            dest_base <= 1'b0;
            state     <= S_MPROD;
          end else begin
            e         <= e >> 1;
            xsel      <= SEL_BASE;
            ysel      <= SEL_BASE;
            dest_base <= 1'b1;
            state     <= S_MPROD;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid   <= 1'b1;
            rsp.r_coef0 <= rr[0];
            rsp.r_coef1 <= rr[1];
            rsp.r_coef2 <= rr[2];
            rsp.r_coef3 <= rr[3];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("accepted a second transaction while busy");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done step");
  a_mac_while_busy: assert property (@(posedge clk) disable iff (rst)
    mac_rsp.done |-> (state == S_RED || state == S_MPROD || state == S_MRED))
    else $error("unit answered outside a compute step");
`endif

endmodule

>>> sim/tb_extension_field_alu.sv
`timescale 1ns / 1ps

module tb_extension_field_alu;

  localparam int  MAX_MISMATCH_PRINT = 10;
  localparam longint CYCLE_LIMIT     = 200_000_000;

  typedef struct {
    logic [1:0]                   func;
    gfa_pkg::vec_t                a;
    gfa_pkg::vec_t                b;
    logic [gfa_pkg::EXP_BITS-1:0] exponent;
  } operands_t;

  // Expected field results and their comparison against the block
  class gf_result_board;
    int unsigned   q;
    int unsigned   n_reg;
    int unsigned   poly [gfa_pkg::MAX_DEGREE];
    gfa_pkg::vec_t expected_results [$];
    int            mismatches;

    function new();
      q = 2;
      n_reg = 1;
      foreach (poly[i]) poly[i] = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [gfa_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
      if (idx == gfa_pkg::REG_MODULUS) q = val & 11'h7ff;
      else if (idx == gfa_pkg::REG_DEGREE) n_reg = val & 4'hf;
      else if (idx >= gfa_pkg::REG_POLY0 && idx < gfa_pkg::REG_POLY0 + gfa_pkg::MAX_DEGREE)
        poly[idx - gfa_pkg::REG_POLY0] = val & 11'h7ff;
    endfunction

    // Product of two residues, reduced by the monic polynomial
    function void field_mul(input longint unsigned x [gfa_pkg::MAX_DEGREE],
                            input longint unsigned y [gfa_pkg::MAX_DEGREE],
                            input longint unsigned p [gfa_pkg::MAX_DEGREE],
                            output longint unsigned r [gfa_pkg::MAX_DEGREE],
                            input int n, input longint unsigned m);
      longint unsigned c [2*gfa_pkg::MAX_DEGREE];
      longint unsigned t;
      foreach (c[i]) c[i] = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          c[i+j] = (c[i+j] + x[i] * y[j]) % m;
      for (int k = 2*n - 2; k >= n; k--) begin
        t = c[k];
        if (t != 0)
          for (int j = 0; j < n; j++)
            c[k-n+j] = (c[k-n+j] + m - (t * p[j]) % m) % m;
        c[k] = 0;
      end
      for (int i = 0; i < gfa_pkg::MAX_DEGREE; i++) r[i] = (i < n) ? c[i] : 0;
    endfunction

    function gfa_pkg::vec_t predict_result(operands_t op);
      longint unsigned a [gfa_pkg::MAX_DEGREE], b [gfa_pkg::MAX_DEGREE];
      longint unsigned p [gfa_pkg::MAX_DEGREE], r [gfa_pkg::MAX_DEGREE];
      longint unsigned base [gfa_pkg::MAX_DEGREE], tmp [gfa_pkg::MAX_DEGREE];
      longint unsigned m, e;
      int n;
      gfa_pkg::vec_t res;
      m = q;
      e = 64'(op.exponent);
      n = (n_reg < 1) ? 1 : (n_reg > gfa_pkg::MAX_DEGREE) ? gfa_pkg::MAX_DEGREE : int'(n_reg);
      res = '0;
      if (m < 2) return res;
      for (int i = 0; i < gfa_pkg::MAX_DEGREE; i++) begin
        a[i] = (i < n) ? longint'(op.a[i]) % m : 0;
        b[i] = (i < n) ? longint'(op.b[i]) % m : 0;
        p[i] = (i < n) ? longint'(poly[i]) % m : 0;
        r[i] = 0;
      end
      case (op.func)
        gfa_pkg::FUNC_ADD: for (int i = 0; i < n; i++) r[i] = (a[i] + b[i]) % m;
        gfa_pkg::FUNC_SUB: for (int i = 0; i < n; i++) r[i] = (a[i] + m - b[i]) % m;
        gfa_pkg::FUNC_MUL: field_mul(a, b, p, r, n, m);
        default: begin
          base = a;
          r[0] = 1;
          while (e != 0) begin
            if (e[0]) begin
              field_mul(r, base, p, tmp, n, m);
              r = tmp;
            end
            e = e >> 1;
            field_mul(base, base, p, tmp, n, m);
            base = tmp;
          end
        end
      endcase
      for (int i = 0; i < gfa_pkg::MAX_DEGREE; i++) res[i] = r[i][gfa_pkg::COEF_BITS-1:0];
      return res;
    endfunction

    function void note_operands(operands_t op);
      expected_results = {expected_results, predict_result(op)};
    endfunction

    function void check_result(gfa_pkg::vec_t got);
      gfa_pkg::vec_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_PRINT)
          $display("unexpected result %h", got);
        return;
      end
      want = expected_results.pop_front();
      for (int i = 0; i < gfa_pkg::MAX_DEGREE; i++)
        if (got[i] !== want[i]) begin
          mismatches++;
          if (mismatches <= MAX_MISMATCH_PRINT)
            $display("r_coef%0d mismatch: expected %0d, got %0d", i, want[i], got[i]);
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gfa_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [gfa_pkg::COEF_BITS-1:0]    cfg_data = '0;
  longint cycles = 0;
  bit burst = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  gfa_req_if req ();
  gfa_rsp_if rsp ();
  gf_result_board board = new();

  extension_field_alu dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_extension_field_alu failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.func = '0;
    req.a_coef0 = '0; req.a_coef1 = '0; req.a_coef2 = '0; req.a_coef3 = '0;
    req.b_coef0 = '0; req.b_coef1 = '0; req.b_coef2 = '0; req.b_coef3 = '0;
    req.exponent = '0;
    rsp.ready = 1'b0;
  end

  // Collect results; stall at random, with one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready)
        board.check_result({rsp.r_coef3, rsp.r_coef2, rsp.r_coef1, rsp.r_coef0});
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 20000;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= burst || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic write_reg(logic [gfa_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[gfa_pkg::COEF_BITS-1:0];
    board.set_register(idx, val);
  endtask

  // Drain outstanding transactions, then load a full register set
  task automatic configure(int unsigned m, int unsigned n, int unsigned p0,
                           int unsigned p1, int unsigned p2, int unsigned p3);
    @(posedge clk);
    req.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(gfa_pkg::REG_MODULUS, m);
    write_reg(gfa_pkg::REG_DEGREE, n);
    write_reg(gfa_pkg::REG_POLY0, p0);
    write_reg(gfa_pkg::CFG_IDX_BITS'(gfa_pkg::REG_POLY0 + 1), p1);
    write_reg(gfa_pkg::CFG_IDX_BITS'(gfa_pkg::REG_POLY0 + 2), p2);
    write_reg(gfa_pkg::CFG_IDX_BITS'(gfa_pkg::REG_POLY0 + 3), p3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send(operands_t op);
    if (!burst)
      while ($urandom_range(99) < 12) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    req.valid <= 1'b1;
    req.func <= op.func;
    req.a_coef0 <= op.a[0]; req.a_coef1 <= op.a[1];
    req.a_coef2 <= op.a[2]; req.a_coef3 <= op.a[3];
    req.b_coef0 <= op.b[0]; req.b_coef1 <= op.b[1];
    req.b_coef2 <= op.b[2]; req.b_coef3 <= op.b[3];
    req.exponent <= op.exponent;
    do @(posedge clk); while (!req.ready);
    board.note_operands(op);
  endtask

  function automatic operands_t make_op(logic [1:0] f, int unsigned ac,
                                        int unsigned bc,
                                        logic [gfa_pkg::EXP_BITS-1:0] e);
    operands_t op;
    op.func = f;
    for (int i = 0; i < gfa_pkg::MAX_DEGREE; i++) begin
      op.a[i] = gfa_pkg::COEF_BITS'(ac - i);
      op.b[i] = gfa_pkg::COEF_BITS'(bc + i);
    end
    op.exponent = e;
    return op;
  endfunction

  function automatic operands_t random_op(int unsigned m);
    operands_t op;
    int unsigned sel;
    op.func = 2'($urandom_range(3));
    for (int i = 0; i < gfa_pkg::MAX_DEGREE; i++) begin
      op.a[i] = gfa_pkg::COEF_BITS'(($urandom_range(3) == 0 || m < 2) ?
                                    $urandom_range(2047) : $urandom_range(m - 1));
      op.b[i] = gfa_pkg::COEF_BITS'(($urandom_range(3) == 0 || m < 2) ?
                                    $urandom_range(2047) : $urandom_range(m - 1));
    end
    // Mostly short exponents; a few full width ones
    sel = $urandom_range(99);
    if (sel < 70) op.exponent = gfa_pkg::EXP_BITS'($urandom_range(64));
    else if (sel < 95) op.exponent = gfa_pkg::EXP_BITS'($urandom_range(4095));
    else op.exponent = gfa_pkg::EXP_BITS'($urandom);
    return op;
  endfunction

  task automatic random_phase(int unsigned m, int unsigned n, int count);
    configure(m, n, $urandom_range(2047), $urandom_range(2047),
              $urandom_range(2047), $urandom_range(2047));
    for (int k = 0; k < count; k++) send(random_op(m));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: GF(7^4) with x^4 + x + 3, field extremes, every operation
    configure(7, 4, 3, 1, 0, 0);
    send(make_op(gfa_pkg::FUNC_ADD, 2047, 2047, 0));
    send(make_op(gfa_pkg::FUNC_SUB, 0, 2047, 0));
    send(make_op(gfa_pkg::FUNC_SUB, 6, 6, 32'hffff_ffff));
    send(make_op(gfa_pkg::FUNC_MUL, 2047, 2047, 0));
    send(make_op(gfa_pkg::FUNC_MUL, 5, 3, 0));
    send(make_op(gfa_pkg::FUNC_POW, 5, 0, 0));
    send(make_op(gfa_pkg::FUNC_POW, 5, 0, 1));
    send(make_op(gfa_pkg::FUNC_POW, 2047, 0, 32'hffff_ffff));
    send(make_op(gfa_pkg::FUNC_POW, 0, 0, 32'h8000_0000));
    // Integer case, degree 1
    configure(2047, 1, 2047, 2047, 2047, 2047);
    send(make_op(gfa_pkg::FUNC_MUL, 2046, 2047, 0));
    send(make_op(gfa_pkg::FUNC_POW, 3, 0, 32'hffff_fffe));
    send(make_op(gfa_pkg::FUNC_ADD, 2047, 2047, 0));
    // Degree zero and above the maximum
    configure(5, 0, 1, 2, 3, 4);
    send(make_op(gfa_pkg::FUNC_MUL, 7, 9, 0));
    configure(5, 7, 1, 2, 3, 4);
    send(make_op(gfa_pkg::FUNC_MUL, 7, 9, 0));
    send(make_op(gfa_pkg::FUNC_POW, 2, 0, 100));
    // Modulus below two
    configure(1, 4, 0, 0, 0, 0);
    send(make_op(gfa_pkg::FUNC_ADD, 2047, 1, 0));
    send(make_op(gfa_pkg::FUNC_POW, 3, 0, 5));
    configure(0, 2, 0, 0, 0, 0);
    send(make_op(gfa_pkg::FUNC_POW, 3, 0, 0));
    send(make_op(gfa_pkg::FUNC_SUB, 3, 5, 0));

    // Random part; the long receiver hold-off starts as the first phase sends
    configure(13, 3, $urandom_range(2047), $urandom_range(2047),
              $urandom_range(2047), $urandom_range(2047));
    hold_req = 1'b1;
    for (int k = 0; k < 110; k++) send(random_op(13));
    random_phase(2, 1, 110);
    random_phase(2047, 4, 110);
    burst = 1'b1;
    random_phase(3, 2, 110);
    burst = 1'b0;
    random_phase(1999, 2, 110);
    random_phase(7, 0, 60);
    random_phase(11, 7, 60);
    random_phase(1, 3, 40);
    random_phase(0, 4, 40);
    random_phase(1024, 4, 110);
    random_phase(2, 4, 110);

    @(posedge clk);
    req.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0)
      $display("tb_extension_field_alu passed");
    else
      $display("tb_extension_field_alu failed");
    $finish;
  end
endmodule
